// File: rtl/mli2c_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mli2c_pkg
// Types and constants of the multi-lane I2C master bit engine: request and
// response structs, command codes and lane helpers.
// ----------------------------------------------------------------------------
package mli2c_pkg;

  localparam int unsigned Lanes       = 5;
  localparam int unsigned SdaWidth    = 5;
  localparam int unsigned PhaseWidth  = 5;
  localparam logic [7:0]  BitMsb      = 8'h80;
  localparam logic [4:0]  PhaseAck    = 5'd18;
  localparam logic [3:0]  BitAck      = 4'd8;

  localparam logic [SdaWidth-1:0] AllLanes =
      SdaWidth'(((64'd1 << Lanes) - 64'd1) & ((64'd1 << SdaWidth) - 64'd1));

  typedef enum logic [2:0] {
    OpTick    = 3'd0,
    OpStart   = 3'd1,
    OpRestart = 3'd2,
    OpWrite   = 3'd3,
    OpRead    = 3'd4,
    OpStop    = 3'd5
  } op_e;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] data_byte;
    logic       ack_last;
    logic [2:0] lane;
    logic       sda_sample;
  } req_t;

  typedef struct packed {
    logic                scl_level;
    logic [SdaWidth-1:0] sda_levels;
    logic                lane_released;
    logic                busy_res;
    logic                done_res;
    logic [7:0]          rx_byte;
    logic                acked;
  } rsp_t;

  function automatic logic [SdaWidth-1:0] lane_mask(input logic [2:0] lane);
    logic [SdaWidth-1:0] m;
    m = '0;
    if ((32'(lane) < Lanes) && (32'(lane) < SdaWidth)) begin
      m[lane] = 1'b1;
    end
    return m;
  endfunction

  function automatic logic [SdaWidth-1:0] drive_lane(input logic [SdaWidth-1:0] sda,
                                                     input logic [SdaWidth-1:0] m,
                                                     input logic level);
    return level ? (sda | m) : (sda & ~m);
  endfunction

endpackage
`default_nettype wire

// File: rtl/multi_lane_i2c_master_bit_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multi_lane_i2c_master_bit_engine
// I2C master with one shared SCL and several SDA lanes, advanced one
// half-bit phase per tick request.
// ----------------------------------------------------------------------------
// channel | direction | handshake                    | payload
// req     | in        | req_valid_i / req_ready_o    | req_i (req_t)
// rsp     | out       | rsp_valid_o / rsp_ready_i    | rsp_o (rsp_t)
//
// Every request yields one response, registered and presented in the cycle after it is accepted.
// One request per cycle while the response register is empty or being drained: the bus
// state updates in the accepting cycle and the response register loads in parallel.
// req_ready_o is high while the response register is empty or being drained.
// Reset puts SCL and all lanes high and the engine idle.
// ----------------------------------------------------------------------------
module multi_lane_i2c_master_bit_engine
  import mli2c_pkg::*;
(
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  req_valid_i,
  output logic req_ready_o,
  input  req_t req_i,
  output logic rsp_valid_o,
  input  wire  rsp_ready_i,
  output rsp_t rsp_o
);

  logic [PhaseWidth-1:0] phase_q, phase_d;
  op_e                   cmd_q, cmd_d;
  logic [7:0]            shift_q, shift_d;
  logic [2:0]            lane_q, lane_d;
  logic                  nak_q, nak_d;
  logic                  scl_q, scl_d;
  logic [SdaWidth-1:0]   sda_q, sda_d;
  logic                  rel_q, rel_d;
  logic                  ack_q, ack_d;
  logic [7:0]            rx_q, rx_d;
  logic                  done;
  logic                  use_write;
  logic [PhaseWidth-1:0] q;
  logic [3:0]            k;
  logic [SdaWidth-1:0]   m;
  logic                  req_fire;
  logic                  rsp_valid_q;
  rsp_t                  rsp_q, rsp_d;

  assign req_ready_o = !rsp_valid_q || rsp_ready_i;
  assign req_fire    = req_valid_i && req_ready_o;
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  always_comb begin
    phase_d   = phase_q;
    cmd_d     = cmd_q;
    shift_d   = shift_q;
    lane_d    = lane_q;
    nak_d     = nak_q;
    scl_d     = scl_q;
    sda_d     = sda_q;
    rel_d     = rel_q;
    ack_d     = ack_q;
    rx_d      = rx_q;
    done      = 1'b0;
    use_write = 1'b0;
    q         = phase_q;
    k         = '0;
    m         = lane_mask(lane_q);
    if (req_i.op == OpTick) begin
      if (cmd_q != OpTick) begin
        phase_d = phase_q + 5'd1;
        unique case (cmd_q)
          OpStart: begin
            if (phase_q == '0) begin
              scl_d = 1'b0;
            end else begin
              use_write = 1'b1;
              q         = phase_q - 5'd1;
            end
          end
          OpRestart: begin
            if (phase_q == '0) begin
              sda_d = sda_q & ~AllLanes;
            end else if (phase_q == 5'd1) begin
              scl_d = 1'b0;
            end else begin
              use_write = 1'b1;
              q         = phase_q - 5'd2;
            end
          end
          OpWrite: begin
            use_write = 1'b1;
          end
          OpRead: begin
            k = q[4:1];
            if (q >= PhaseAck) begin
              scl_d   = 1'b0;
              sda_d   = drive_lane(sda_q, m, 1'b1);
              rx_d    = shift_q;
              cmd_d   = OpTick;
              phase_d = '0;
              done    = 1'b1;
            end else if (!q[0]) begin
              scl_d = 1'b0;
              if (k == BitAck) begin
                rel_d = 1'b0;
                sda_d = drive_lane(sda_q, m, nak_q);
              end
            end else begin
              scl_d = 1'b1;
              if (k < BitAck) begin
                shift_d = {shift_q[6:0], req_i.sda_sample};
              end
            end
          end
          OpStop: begin
            if (phase_q == '0) begin
              scl_d = 1'b1;
            end else if (phase_q == 5'd1) begin
              sda_d = sda_q | AllLanes;
            end else begin
              cmd_d   = OpTick;
              phase_d = '0;
              done    = 1'b1;
            end
          end
          default: begin
            cmd_d   = OpTick;
            phase_d = '0;
          end
        endcase
        if (use_write) begin
          k = q[4:1];
          if (q >= PhaseAck) begin
            scl_d   = 1'b0;
            rel_d   = 1'b0;
            cmd_d   = OpTick;
            phase_d = '0;
            done    = 1'b1;
          end else if (!q[0]) begin
            scl_d = 1'b0;
            if (k < BitAck) begin
              sda_d = drive_lane(sda_q, m, (shift_q & (BitMsb >> k[2:0])) != '0);
            end else begin
              sda_d = drive_lane(sda_q, m, 1'b1);
              rel_d = 1'b1;
            end
          end else begin
            scl_d = 1'b1;
            if (k == BitAck) begin
              ack_d = !req_i.sda_sample;
            end
          end
        end
      end
    end else if ((req_i.op <= OpStop) && (cmd_q == OpTick)) begin
      cmd_d   = op_e'(req_i.op);
      phase_d = '0;
      lane_d  = req_i.lane;
      nak_d   = req_i.ack_last;
      shift_d = req_i.data_byte;
      m       = lane_mask(req_i.lane);
      unique case (op_e'(req_i.op))
        OpStart, OpStop: begin
          sda_d = sda_q & ~AllLanes;
        end
        OpRestart: begin
          scl_d = 1'b1;
        end
        OpRead: begin
          shift_d = '0;
          sda_d   = drive_lane(sda_q, m, 1'b1);
          rel_d   = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    rsp_d.scl_level     = scl_d;
    rsp_d.sda_levels    = sda_d;
    rsp_d.lane_released = rel_d;
    rsp_d.busy_res      = cmd_d != OpTick;
    rsp_d.done_res      = done;
    rsp_d.rx_byte       = rx_d;
    rsp_d.acked         = ack_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= '0;
      cmd_q       <= OpTick;
      shift_q     <= '0;
      lane_q      <= '0;
      nak_q       <= 1'b0;
      scl_q       <= 1'b1;
      sda_q       <= '1;
      rel_q       <= 1'b0;
      ack_q       <= 1'b0;
      rx_q        <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (req_fire) begin
        phase_q     <= phase_d;
        cmd_q       <= cmd_d;
        shift_q     <= shift_d;
        lane_q      <= lane_d;
        nak_q       <= nak_d;
        scl_q       <= scl_d;
        sda_q       <= sda_d;
        rel_q       <= rel_d;
        ack_q       <= ack_d;
        rx_q        <= rx_d;
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      rsp_q <= rsp_d;
    end
  end

endmodule
`default_nettype wire
